// ===== hdl/lfpe_pkg.sv =====
// Shared constants, types and handshake structs of the lidar frame point extractor.
package lfpe_pkg;

    // Frame geometry
    localparam int POINTS    = 12;
    localparam int FRAME_LEN = 11 + 3 * POINTS;

    // Field and internal widths
    localparam int BYTE_W  = 8;
    localparam int HUNT_W  = 12;
    localparam int IDX_W   = 7;
    localparam int RAW_W   = 16;
    localparam int SPAN_W  = RAW_W + 2;
    localparam int DIST_W  = 16;
    localparam int ANGLE_W = 24;
    localparam int PT_W    = $clog2(POINTS);
    localparam int REM_W   = $clog2(POINTS);
    localparam int QUO_W   = RAW_W + 8;

    // Reciprocal of POINTS-1 for the angle step: exact floor over QUO_W-bit dividends
    localparam int DIV_SH  = QUO_W + $clog2(POINTS - 1);
    localparam int RECIP_W = QUO_W + 1;
    localparam int PROD_W  = RAW_W + RECIP_W;
    localparam int Q_SH    = DIV_SH - 8;

    // APB port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Angle arithmetic
    localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(9216000);
    localparam logic [SPAN_W-1:0]  RAW_TURN  = SPAN_W'(36000);
    localparam logic [REM_W:0]     DIVISOR   = (REM_W + 1)'(POINTS - 1);
    localparam logic [RECIP_W-1:0] RECIP     =
        RECIP_W'(((longint'(1) << DIV_SH) + longint'(POINTS - 2)) / longint'(POINTS - 1));

    // Byte positions inside a frame
    localparam logic [IDX_W-1:0] IDX_AFTER_HDR  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_START_LO   = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_START_HI   = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_DIST_FIRST = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_END_LO     = IDX_W'(6 + 3 * POINTS);
    localparam logic [IDX_W-1:0] IDX_END_HI     = IDX_W'(7 + 3 * POINTS);
    localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(FRAME_LEN - 1);

    // Position inside one 3-byte point record
    localparam logic [1:0] REC_DIST_LO = 2'd0;
    localparam logic [1:0] REC_DIST_HI = 2'd1;
    localparam logic [1:0] REC_INTENS  = 2'd2;

    // Register indexes and reset values
    localparam logic [1:0] REG_HEAD       = 2'd0;
    localparam logic [1:0] REG_VER_LEN    = 2'd1;
    localparam logic [1:0] REG_HUNT_LIMIT = 2'd2;

    localparam logic [BYTE_W-1:0] HEAD_RST  = BYTE_W'(84);
    localparam logic [BYTE_W-1:0] VER_RST   = BYTE_W'(44);
    localparam logic [HUNT_W-1:0] LIMIT_RST = HUNT_W'(1000);

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_VER,
        PH_COLLECT
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PARSE,
        S_PREP,
        S_DIV_LOAD,
        S_DIV,
        S_QFIX,
        S_EMIT_RD,
        S_EMIT_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] ver_len;
        logic [HUNT_W-1:0] hunt_limit;
    } cfg_t;

    typedef struct packed {
        logic take_byte;
        logic commit;
        logic out_timeout;
        logic prep;
        logic div_load;
        logic div_step;
        logic qfix;
        logic rd;
        logic out_point;
    } lfpe_cmd_t;

    typedef struct packed {
        logic fail_emit;
        logic frame_end;
        logic out_free;
        logic last_point;
    } lfpe_stat_t;

endpackage

// ===== hdl/lfpe_ram.sv =====
// Generic single-port-write, registered-read RAM.
module lfpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lfpe_cfg.sv =====
// APB register file: header bytes and hunt limit.
module lfpe_cfg import lfpe_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [BYTE_W-1:0] head_reg;
    logic [BYTE_W-1:0] ver_reg;
    logic [HUNT_W-1:0] limit_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= HEAD_RST;
            ver_reg   <= VER_RST;
            limit_reg <= LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HEAD:       head_reg  <= pwdata[BYTE_W-1:0];
                REG_VER_LEN:    ver_reg   <= pwdata[BYTE_W-1:0];
                REG_HUNT_LIMIT: limit_reg <= pwdata[HUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HEAD:       prdata = DATA_W'(head_reg);
            REG_VER_LEN:    prdata = DATA_W'(ver_reg);
            REG_HUNT_LIMIT: prdata = DATA_W'(limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.head       = head_reg;
    assign cfg.ver_len    = ver_reg;
    assign cfg.hunt_limit = limit_reg;

endmodule

// ===== hdl/lfpe_ctrl.sv =====
// Sequencer: byte parse, angle-step computation and point emission.
module lfpe_ctrl import lfpe_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  lfpe_stat_t st,
    output lfpe_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                // timeout result waits for a free output register
                if (!(st.fail_emit && !st.out_free))
                begin
                    state_next = st.frame_end ? S_PREP : S_IDLE;
                end
            end
            S_PREP:     state_next = S_DIV_LOAD;
            S_DIV_LOAD: state_next = S_DIV;
            S_DIV:      state_next = S_QFIX;
            S_QFIX:     state_next = S_EMIT_RD;
            S_EMIT_RD:  state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (st.out_free)
                begin
                    state_next = st.last_point ? S_IDLE : S_EMIT_RD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.take_byte = in_valid;
            end
            S_PARSE:
            begin
                if (!(st.fail_emit && !st.out_free))
                begin
                    cmd.commit      = 1'b1;
                    cmd.out_timeout = st.fail_emit;
                end
            end
            S_PREP:     cmd.prep     = 1'b1;
            S_DIV_LOAD: cmd.div_load = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_QFIX:     cmd.qfix     = 1'b1;
            S_EMIT_RD:  cmd.rd       = 1'b1;
            S_EMIT_OUT: cmd.out_point = st.out_free;
            default:    ;
        endcase
    end

    a_take_to_parse: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_PARSE))
        else $error("input transfer not followed by parse");

    a_qfix_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QFIX) |-> ($past(state_reg) == S_DIV))
        else $error("quotient fix without remainder step");

endmodule

// ===== hdl/lfpe_dp.sv =====
// Datapath: header hunt, frame capture, angle interpolation and result register.
module lfpe_dp import lfpe_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  lfpe_cmd_t           cmd,
    output lfpe_stat_t          st,
    input  logic [BYTE_W-1:0]   rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output logic [ANGLE_W-1:0]  angle,
    output logic [DIST_W-1:0]   distance,
    output logic                last
);

    // Frame parse state
    logic [BYTE_W-1:0] byte_reg;
    phase_t            phase_reg,  phase_next;
    logic [HUNT_W-1:0] hunt_reg,   hunt_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [BYTE_W-1:0] low_reg,    low_next;
    logic [RAW_W-1:0]  start_reg,  start_next;
    logic [RAW_W-1:0]  end_reg,    end_next;
    logic [1:0]        rec_reg,    rec_next;
    logic [PT_W-1:0]   slot_reg,   slot_next;

    // Interpolation state
    logic [SPAN_W-1:0]  span_reg;
    logic               neg_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [REM_W-1:0]   drem_reg;
    logic [ANGLE_W-1:0] acc_reg;
    logic [REM_W-1:0]   racc_reg;
    logic [PT_W-1:0]    emit_reg;

    // Result register
    logic               out_valid_reg;
    logic               status_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               last_reg;

    logic               is_head;
    logic               is_ver;
    logic               fail;
    logic [HUNT_W-1:0]  hunt_inc;
    logic               ram_we;
    logic [DIST_W-1:0]  ram_rdata;

    logic [SPAN_W-1:0]  diff;
    logic [ANGLE_W-1:0] start_sh;
    logic [SPAN_W-1:0]  span_mag;
    logic [QUO_W-1:0]   dvd;
    logic [PROD_W-1:0]  recip_prod;
    logic [QUO_W-1:0]   quo_load;
    logic [QUO_W-1:0]   q_back;
    logic [REM_W:0]     rsum;
    logic               carry;
    logic [ANGLE_W:0]   step;
    logic [ANGLE_W:0]   acc_tmp;
    logic [ANGLE_W-1:0] acc_adv;
    logic               out_free;

    // ---------------- header hunt and frame capture ----------------
    assign is_head  = (byte_reg == cfg.head);
    assign is_ver   = (byte_reg == cfg.ver_len);
    assign fail     = ((phase_reg == PH_HEAD) && !is_head) ||
                      ((phase_reg == PH_VER) && !is_ver);
    assign hunt_inc = hunt_reg + HUNT_W'(1);

    assign st.fail_emit  = fail && (hunt_inc >= cfg.hunt_limit);
    assign st.frame_end  = (phase_reg == PH_COLLECT) && (idx_reg >= IDX_LAST);

    always_comb
    begin
        phase_next = phase_reg;
        hunt_next  = hunt_reg;
        idx_next   = idx_reg;
        low_next   = low_reg;
        start_next = start_reg;
        end_next   = end_reg;
        rec_next   = rec_reg;
        slot_next  = slot_reg;
        ram_we     = 1'b0;
        if (cmd.commit)
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    if (is_head)
                    begin
                        phase_next = PH_VER;
                    end
                    else
                    begin
                        hunt_next = st.fail_emit ? '0 : hunt_inc;
                    end
                end
                PH_VER:
                begin
                    if (is_ver)
                    begin
                        phase_next = PH_COLLECT;
                        hunt_next  = '0;
                        idx_next   = IDX_AFTER_HDR;
                    end
                    else
                    begin
                        phase_next = PH_HEAD;
                        hunt_next  = st.fail_emit ? '0 : hunt_inc;
                    end
                end
                PH_COLLECT:
                begin
                    if (idx_reg == IDX_START_LO)
                    begin
                        low_next = byte_reg;
                    end
                    else if (idx_reg == IDX_START_HI)
                    begin
                        start_next = {byte_reg, low_reg};
                        rec_next   = REC_DIST_LO;
                        slot_next  = '0;
                    end
                    else if (idx_reg >= IDX_DIST_FIRST && idx_reg < IDX_END_LO)
                    begin
                        if (rec_reg == REC_DIST_LO)
                        begin
                            low_next = byte_reg;
                        end
                        else if (rec_reg == REC_DIST_HI)
                        begin
                            ram_we = 1'b1;
                        end
                        if (rec_reg == REC_INTENS)
                        begin
                            rec_next  = REC_DIST_LO;
                            slot_next = slot_reg + PT_W'(1);
                        end
                        else
                        begin
                            rec_next = rec_reg + 2'd1;
                        end
                    end
                    else if (idx_reg == IDX_END_LO)
                    begin
                        low_next = byte_reg;
                    end
                    else if (idx_reg == IDX_END_HI)
                    begin
                        end_next = {byte_reg, low_reg};
                    end

                    if (st.frame_end)
                    begin
                        phase_next = PH_HEAD;
                        hunt_next  = '0;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                default: phase_next = PH_HEAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            hunt_reg  <= '0;
            idx_reg   <= '0;
            rec_reg   <= REC_DIST_LO;
            slot_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hunt_reg  <= hunt_next;
            idx_reg   <= idx_next;
            rec_reg   <= rec_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            byte_reg <= rx_byte;
        end
        low_reg   <= low_next;
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    lfpe_ram #(
        .WIDTH (DIST_W),
        .DEPTH (POINTS)
    ) u_dist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({byte_reg, low_reg}),
        .re    (cmd.rd),
        .raddr (emit_reg),
        .rdata (ram_rdata)
    );

    // ---------------- interpolation ----------------
    // span gets a full turn added when negative; may still be negative for raw angles above a full turn
    assign diff     = {2'b00, end_reg} - {2'b00, start_reg};
    assign start_sh = {start_reg, 8'h00};
    assign span_mag = span_reg[SPAN_W-1] ? (~span_reg + SPAN_W'(1)) : span_reg;

    // |span|*256 / (POINTS-1) by reciprocal multiply, remainder in the next cycle
    assign dvd        = {span_mag[RAW_W-1:0], 8'h00};
    assign recip_prod = PROD_W'(span_mag[RAW_W-1:0]) * PROD_W'(RECIP);
    assign quo_load   = QUO_W'(recip_prod >> Q_SH);
    assign q_back     = quo_reg * QUO_W'(POINTS - 1);

    // per point: quotient step plus carry from the accumulated remainder
    assign rsum    = {1'b0, racc_reg} + {1'b0, drem_reg};
    assign carry   = (rsum >= DIVISOR);
    assign step    = {1'b0, quo_reg} + (ANGLE_W + 1)'(carry);
    assign acc_tmp = neg_reg ? ({1'b0, acc_reg} - step) : ({1'b0, acc_reg} + step);

    always_comb
    begin
        if (neg_reg)
        begin
            acc_adv = acc_tmp[ANGLE_W] ? (acc_tmp[ANGLE_W-1:0] + FULL_TURN)
                                       : acc_tmp[ANGLE_W-1:0];
        end
        else
        begin
            acc_adv = (acc_tmp >= {1'b0, FULL_TURN}) ? (acc_tmp[ANGLE_W-1:0] - FULL_TURN)
                                                     : acc_tmp[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= '0;
        end
        else
        begin
            if (cmd.prep)
            begin
                emit_reg <= '0;
            end
            else if (cmd.out_point)
            begin
                emit_reg <= emit_reg + PT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            span_reg <= diff[SPAN_W-1] ? (diff + RAW_TURN) : diff;
            acc_reg  <= (start_sh >= FULL_TURN) ? (start_sh - FULL_TURN) : start_sh;
            racc_reg <= '0;
        end
        else if (cmd.out_point)
        begin
            acc_reg  <= acc_adv;
            racc_reg <= carry ? REM_W'(rsum - DIVISOR) : rsum[REM_W-1:0];
        end

        if (cmd.div_load)
        begin
            neg_reg  <= span_reg[SPAN_W-1];
            quo_reg  <= quo_load;
            drem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            drem_reg <= REM_W'(dvd - q_back);
        end
        else if (cmd.qfix)
        begin
            quo_reg <= (quo_reg >= FULL_TURN) ? (quo_reg - FULL_TURN) : quo_reg;
        end
    end

    assign st.last_point = (emit_reg == PT_W'(POINTS - 1));

    // ---------------- result register ----------------
    assign out_free    = !out_valid_reg || !out_stall;
    assign st.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_timeout || cmd.out_point)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_timeout)
        begin
            status_reg <= 1'b1;
            angle_reg  <= '0;
            dist_reg   <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.out_point)
        begin
            status_reg <= 1'b0;
            angle_reg  <= acc_reg;
            dist_reg   <= ram_rdata;
            last_reg   <= st.last_point;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign angle     = angle_reg;
    assign distance  = dist_reg;
    assign last      = last_reg;

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (angle_reg < FULL_TURN))
        else $error("result angle not reduced below a full turn");

    a_timeout_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (angle_reg == '0 && dist_reg == '0 && last_reg))
        else $error("malformed sync timeout result");

    a_emit_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_point |-> (phase_reg == PH_HEAD && idx_reg == '0))
        else $error("point emitted while a frame is still open");

endmodule

// ===== hdl/lidar_frame_point_extractor_top.sv =====
// Top level of the lidar frame point extractor.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  input    | in_valid/in_stall  | rx_byte[7:0]
//  output   | out_valid/out_stall| status, angle[23:0], distance[15:0], last
//  config   | APB psel/penable   | paddr[3:0], pwdata/prdata[31:0]
//
// Sequence: an ordinary byte is transferred, then parsed, before the
// next byte is taken. The closing byte of a frame adds span setup,
// reciprocal multiply for the angle step, remainder and quotient check,
// then per point a distance RAM read and a result load, which waits for a
// free result register.
// Reset: rst_n is asynchronous, active low; the hunt restarts from scratch,
// registers return to head 84, version/length 44, hunt limit 1000.
// Stalls: the result register holds its transfer under out_stall; a byte may
// be taken while a result still waits, and the sequencer holds only when it
// needs that register.
module lidar_frame_point_extractor_top import lfpe_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // byte input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    // results
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [ANGLE_W-1:0] angle,
    output logic [DIST_W-1:0]  distance,
    output logic               last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    cfg_t       cfg;
    lfpe_cmd_t  cmd;
    lfpe_stat_t st;

    // register file
    lfpe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: owns the input handshake, drives the datapath by commands
    lfpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: frame parser, angle step, angle accumulator, result register
    lfpe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .angle     (angle),
        .distance  (distance),
        .last      (last)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the lidar frame point extractor: byte stream in, points out.
`timescale 1ns / 1ps

module testbench;
    import lfpe_pkg::*;

    // Run limits: the cycle budget is many times the slowest legal run, and
    // SETTLE covers the longest frame-end computation.
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 64;
    localparam int MAX_SHOWN   = 10;

    // Result status codes
    localparam logic STATUS_POINT   = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    // Register slot that does not exist; writes to it must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Angle arithmetic in signed 64-bit terms
    localparam longint TURN_RAW  = longint'(RAW_TURN);
    localparam longint TURN_FULL = longint'(FULL_TURN);

    typedef struct packed {
        logic               status;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  distance;
        logic               last;
    } point_rec_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  rx_byte    = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic               status;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
    logic               last;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [ADDR_W-1:0]  paddr      = '0;
    logic [DATA_W-1:0]  pwdata     = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    lidar_frame_point_extractor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .angle     (angle),
        .distance  (distance),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder mirror: its own copy of registers and frame state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] cfg_head  = HEAD_RST;
    logic [BYTE_W-1:0] cfg_ver   = VER_RST;
    logic [HUNT_W-1:0] cfg_limit = LIMIT_RST;

    phase_t            frame_phase = PH_HEAD;
    logic [HUNT_W-1:0] hunt_tally  = '0;
    logic [IDX_W-1:0]  byte_pos    = '0;
    logic [BYTE_W-1:0] low_hold    = '0;
    logic [RAW_W-1:0]  start_raw   = '0;
    logic [RAW_W-1:0]  stop_raw    = '0;
    logic [DIST_W-1:0] dist_mem [POINTS];

    // Points and timeouts the decoder owes us, oldest first
    point_rec_t decoded_points [$];

    // Distances used by the next frame that send_frame builds
    logic [DIST_W-1:0] frame_dist [POINTS];

    int  err_count     = 0;
    int  bytes_sent    = 0;
    int  points_seen   = 0;
    int  timeouts_seen = 0;
    int  reg_writes    = 0;
    int  cycle_count   = 0;
    bit  idle_on       = 1'b1;

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Linear interpolation between start and end angle, 1/25600 degree.
    // End below start adds a full turn; whatever is still out of range
    // (start above 360 deg, span still negative) falls to the modulo.
    function automatic logic [ANGLE_W-1:0] point_angle(input int i);
        longint s;
        longint e;
        longint span;
        longint a;
        s = start_raw;
        e = stop_raw;
        span = e - s;
        if (span < 0)
            span += TURN_RAW;
        a = s * 256 + (span * 256 * i) / (POINTS - 1);
        a = a % TURN_FULL;
        if (a < 0)
            a += TURN_FULL;
        return a[ANGLE_W-1:0];
    endfunction

    // One failed header attempt; report a timeout when the tally hits the limit
    task automatic count_hunt_miss();
        frame_phase = PH_HEAD;
        hunt_tally  = hunt_tally + 1'b1;
        if (hunt_tally >= cfg_limit)
        begin
            hunt_tally = '0;
            decoded_points.push_back('{STATUS_TIMEOUT, '0, '0, 1'b1});
        end
    endtask

    // Advance the mirror by one accepted byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        int off;
        case (frame_phase)
            PH_HEAD:
            begin
                if (b == cfg_head)
                    frame_phase = PH_VER;
                else
                    count_hunt_miss();
            end
            PH_VER:
            begin
                if (b == cfg_ver)
                begin
                    frame_phase = PH_COLLECT;
                    hunt_tally  = '0;
                    byte_pos    = IDX_AFTER_HDR;
                end
                else
                    count_hunt_miss();
            end
            default:
            begin
                off = int'(byte_pos) - int'(IDX_DIST_FIRST);
                if (byte_pos == IDX_START_LO)
                    low_hold = b;
                else if (byte_pos == IDX_START_HI)
                    start_raw = {b, low_hold};
                else if (byte_pos >= IDX_DIST_FIRST && byte_pos < IDX_END_LO)
                begin
                    if (off % 3 == REC_DIST_LO)
                        low_hold = b;
                    else if (off % 3 == REC_DIST_HI)
                        dist_mem[off / 3] = {b, low_hold};
                end
                else if (byte_pos == IDX_END_LO)
                    low_hold = b;
                else if (byte_pos == IDX_END_HI)
                    stop_raw = {b, low_hold};

                if (byte_pos == IDX_LAST)
                begin
                    frame_phase = PH_HEAD;
                    hunt_tally  = '0;
                    byte_pos    = '0;
                    for (int i = 0; i < POINTS; i++)
                        decoded_points.push_back('{STATUS_POINT, point_angle(i), dist_mem[i],
                                                   i == POINTS - 1});
                end
                else
                    byte_pos = byte_pos + 1'b1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Byte sender: holds the byte until taken, then maybe idles a while.
    // in_valid stays up across back-to-back transfers (no drop and raise
    // in the same step).
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        rx_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
        if (idle_on && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Full well-formed frame using the current header registers and frame_dist.
    // Speed, intensity, timestamp and CRC bytes are random filler.
    task automatic send_frame(input logic [RAW_W-1:0] start_a, input logic [RAW_W-1:0] stop_a);
        send_byte(cfg_head);
        send_byte(cfg_ver);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(start_a[7:0]);
        send_byte(start_a[15:8]);
        for (int i = 0; i < POINTS; i++)
        begin
            send_byte(frame_dist[i][7:0]);
            send_byte(frame_dist[i][15:8]);
            send_byte(8'($urandom));
        end
        send_byte(stop_a[7:0]);
        send_byte(stop_a[15:8]);
        repeat (3) send_byte(8'($urandom));
    endtask

    // Stop sending, let every owed result drain, then give the block time
    // to finish any work that produces nothing (the last byte's parse).
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (decoded_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB access: setup cycle, access cycle, then the bus idles after
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_HEAD:       cfg_head  = val[BYTE_W-1:0];
            REG_VER_LEN:    cfg_ver   = val[BYTE_W-1:0];
            REG_HUNT_LIMIT: cfg_limit = val[HUNT_W-1:0];
            default:        ;
        endcase
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check(input logic [1:0] idx);
        logic [DATA_W-1:0] want;
        case (idx)
            REG_HEAD:       want = DATA_W'(cfg_head);
            REG_VER_LEN:    want = DATA_W'(cfg_ver);
            default:        want = DATA_W'(cfg_limit);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            flag_error($sformatf("register %0d read %0h, want %0h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all three registers on an idle block and read them back
    task automatic program_decoder(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] ver,
                                   input logic [HUNT_W-1:0] limit);
        wait_idle();
        apb_write(REG_HEAD, DATA_W'(head));
        apb_write(REG_VER_LEN, DATA_W'(ver));
        apb_write(REG_HUNT_LIMIT, DATA_W'(limit));
        apb_check(REG_HEAD);
        apb_check(REG_VER_LEN);
        apb_check(REG_HUNT_LIMIT);
    endtask

    // ------------------------------------------------------------------
    // Result checker and output-side back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        point_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_points.size() == 0)
                flag_error($sformatf("stray result status=%0d angle=%0d dist=%0d last=%0d",
                                     status, angle, distance, last));
            else
            begin
                want = decoded_points.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status %0d, want %0d", status, want.status));
                if (angle !== want.angle)
                    flag_error($sformatf("angle %0d, want %0d", angle, want.angle));
                if (distance !== want.distance)
                    flag_error($sformatf("distance %0h, want %0h", distance, want.distance));
                if (last !== want.last)
                    flag_error($sformatf("last %0d, want %0d", last, want.last));
                if (want.status == STATUS_TIMEOUT)
                    timeouts_seen++;
                else
                    points_seen++;
            end
        end
        out_stall <= idle_on && ($urandom_range(0, 99) < 37);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_points.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values read back; a write to the unused slot changes nothing
    task automatic test_register_access();
        apb_check(REG_HEAD);
        apb_check(REG_VER_LEN);
        apb_check(REG_HUNT_LIMIT);
        apb_write(REG_UNUSED, '1);
        apb_check(REG_HEAD);
        apb_check(REG_VER_LEN);
        apb_check(REG_HUNT_LIMIT);
    endtask

    // Wrap through zero (end below start), then a start above 360 deg whose
    // span stays negative even after the full-turn correction.
    task automatic test_angle_interpolation();
        for (int i = 0; i < POINTS; i++)
            case (i % 4)
                0: frame_dist[i] = 16'h0000;
                1: frame_dist[i] = 16'hFFFF;
                2: frame_dist[i] = 16'h00FF;
                default: frame_dist[i] = 16'hFF00;
            endcase
        send_frame(16'd35000, 16'd1000);
        for (int i = 0; i < POINTS; i++)
            frame_dist[i] = 16'($urandom);
        send_frame(16'hFFFF, 16'd0);
    endtask

    // Timeout counting: a frame clears the tally, a head byte followed by
    // another head byte is consumed as a bad second byte, and limit zero
    // fires on every miss.
    task automatic test_sync_timeout();
        program_decoder(HEAD_RST, VER_RST, 12'd2);
        send_byte(8'h00);
        for (int i = 0; i < POINTS; i++)
            frame_dist[i] = i[0] ? 16'hFFFF : 16'h0000;
        send_frame(16'd0, 16'd35999);
        send_byte(8'hFF);
        send_byte(HEAD_RST);
        send_byte(HEAD_RST);
        program_decoder(HEAD_RST, VER_RST, 12'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HEAD_RST);
        send_byte(~VER_RST);
    endtask

    function automatic logic [RAW_W-1:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd35999;
            2: return 16'($urandom_range(36000, 65535));
            default: return 16'($urandom_range(0, 35999));
        endcase
    endfunction

    // Mostly full frames with random content, mixed with line noise and
    // headers that break after the head byte.
    task automatic run_traffic(input int budget);
        int first;
        int pick;
        logic [BYTE_W-1:0] b;
        first = bytes_sent;
        while (bytes_sent - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                for (int i = 0; i < POINTS; i++)
                    if ($urandom_range(0, 7) == 0)
                        frame_dist[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    else
                        frame_dist[i] = 16'($urandom);
                send_frame(pick_angle(), pick_angle());
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    b = 8'($urandom);
                    if (b == cfg_head)
                        b = ~b;
                    send_byte(b);
                end
            end
            else
            begin
                b = 8'($urandom);
                if (b == cfg_ver)
                    b = ~b;
                send_byte(cfg_head);
                send_byte(b);
            end
        end
    endtask

    // Three register settings, extremes included; the middle one runs with
    // no idling on either side.
    task automatic test_random_traffic();
        program_decoder(8'h00, 8'hFF, 12'd1);
        run_traffic(20);
        idle_on = 1'b0;
        program_decoder(8'hFF, 8'h00, 12'd4095);
        run_traffic(20);
        idle_on = 1'b1;
        program_decoder(8'($urandom), 8'($urandom), 12'($urandom_range(2, 6)));
        run_traffic(20);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_angle_interpolation();
        test_sync_timeout();
        test_random_traffic();
        wait_idle();

        $display("summary: %0d bytes sent, %0d points and %0d sync timeouts checked",
                 bytes_sent, points_seen, timeouts_seen);
        $display("summary: %0d register writes, %0d mismatches", reg_writes, err_count);
        if (err_count == 0 && decoded_points.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
